### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/qdbs_pkg.sv
// ----------------------------------------------------------------------------
// qdbs_pkg
// Types and constants of the quadrature detent bit stack.
// ----------------------------------------------------------------------------
package qdbs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_TABLE  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CONSUMER_EN = CFG_INDEX_W'(1);

    localparam logic [7:0] CODE_TABLE_RESET = 8'h87;

    localparam logic signed [3:0] POS_PUSH_HI = 4'sd3;
    localparam logic signed [3:0] POS_PUSH_LO = -4'sd3;
    localparam logic signed [4:0] POS_SAT_HI  = 5'sd7;
    localparam logic signed [4:0] POS_SAT_LO  = -5'sd7;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_POP    = 2'd1,
        OP_DRAIN  = 2'd2,
        OP_INIT   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEP,
        ST_EMIT,
        ST_READ,
        ST_RD_EMIT
    } state_t;

endpackage

### rtl/core/quadrature_detent_bit_stack_core.sv
// ----------------------------------------------------------------------------
// quadrature_detent_bit_stack_core
// Quadrature encoder decoder that stacks one direction bit per detent.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   (in_valid/in_ready, op, clk_level, dt_level): one transaction
//                per operation. in_ready is high only while the sequencer idles.
//   out channel  (out_valid/out_ready, has_bit, direction, last): result
//                transactions; last marks the final one of an operation.
//   cfg channel  (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//                index 0 code table, index 1 consumer enable, others ignored.
// Sequencing:
//   Sample and initial sample walk the four-entry code table with one shared
//   2-bit comparator, one entry per cycle, then update the count in ST_STEP
//   and present the result from ST_EMIT; the table scan sets the delay to
//   out_valid. Pop reads through the registered stack read (ST_READ, then
//   ST_RD_EMIT). Drain-all emits one bit per read-then-present pass. Disabled,
//   empty or full-stack ops go straight to ST_EMIT.
// Reset: the count and fill level clear, code table returns to 11,01,00,10,
//   consumer is disabled. The stack contents are not cleared.
// Stall: a result waits in the output register while out_ready is low; the
//   sequencer holds until that register frees, so nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_detent_bit_stack_core
    import qdbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // operation channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             op,
    input  logic                   clk_level,
    input  logic                   dt_level,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   has_bit,
    output logic                   direction,
    output logic                   last,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,     state_next;
    op_t                 op_reg,        op_next;
    logic [1:0]          code_reg,      code_next;
    logic [1:0]          scan_idx_reg,  scan_idx_next;
    logic [1:0]          idx_reg,       idx_next;
    logic signed [3:0]   pos_reg,       pos_next;
    logic [FILL_W-1:0]   fill_reg,      fill_next;
    logic [FILL_W-1:0]   drain_idx_reg, drain_idx_next;
    logic                res_has_reg,   res_has_next;
    logic                res_dir_reg,   res_dir_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_has_reg,   out_has_next;
    logic                out_dir_reg,   out_dir_next;
    logic                out_last_reg,  out_last_next;
    logic [7:0]          code_table_reg;
    logic                enable_reg;

    // bit stack
    logic                mem [STACK_DEPTH];
    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic                mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic                rd_data_reg;

    // shared compare and count update
    logic [1:0]          table_entry;
    logic                entry_hit;
    logic signed [3:0]   diff_raw;
    logic signed [3:0]   diff;
    logic signed [4:0]   pos_sum;
    logic signed [3:0]   pos_sat;
    logic [FILL_W-1:0]   fill_dec;
    logic [FILL_W-1:0]   drain_inc;
    logic                drain_last;

    logic in_fire;
    logic out_free;
    logic cfg_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    assign out_valid = out_valid_reg;
    assign has_bit   = out_has_reg;
    assign direction = out_dir_reg;
    assign last      = out_last_reg;

    // one table entry per scan cycle
    assign table_entry = code_table_reg[{scan_idx_reg, 1'b0} +: 2];
    assign entry_hit   = (table_entry == code_reg);

    // shortest step from the count's phase to the table index;
    // the low two bits of a two's-complement count are its non-negative phase
    assign diff_raw = $signed({2'b00, idx_reg}) - $signed({2'b00, pos_reg[1:0]});
    always_comb
    begin
        diff = diff_raw;
        if (diff_raw == 4'sd3)
        begin
            diff = -4'sd1;
        end
        else if (diff_raw == -4'sd3)
        begin
            diff = 4'sd1;
        end
    end

    assign pos_sum = {pos_reg[3], pos_reg} + {diff[3], diff};
    always_comb
    begin
        if (pos_sum > POS_SAT_HI)
        begin
            pos_sat = POS_SAT_HI[3:0];
        end
        else if (pos_sum < POS_SAT_LO)
        begin
            pos_sat = POS_SAT_LO[3:0];
        end
        else
        begin
            pos_sat = pos_sum[3:0];
        end
    end

    assign fill_dec   = fill_reg - FILL_W'(1);
    assign drain_inc  = drain_idx_reg + FILL_W'(1);
    assign drain_last = (drain_inc == fill_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        code_next      = code_reg;
        scan_idx_next  = scan_idx_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        drain_idx_next = drain_idx_reg;
        res_has_next   = res_has_reg;
        res_dir_next   = res_dir_reg;
        out_has_next   = out_has_reg;
        out_dir_next   = out_dir_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = fill_reg[ADDR_W-1:0];
        mem_wr_data    = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = fill_dec[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next       = op_t'(op);
                    code_next     = {clk_level, dt_level};
                    scan_idx_next = 2'd0;
                    res_has_next  = 1'b0;
                    res_dir_next  = 1'b0;
                    state_next    = ST_EMIT;
                    if (enable_reg)
                    begin
                        case (op_t'(op))
                            OP_SAMPLE:
                            begin
                                // full stack: sample is dropped
                                if (fill_reg < FILL_W'(STACK_DEPTH))
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                            OP_INIT:
                            begin
                                state_next = ST_SCAN;
                            end
                            OP_POP:
                            begin
                                if (fill_reg != '0)
                                begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = fill_dec[ADDR_W-1:0];
                                    fill_next   = fill_dec;
                                    state_next  = ST_READ;
                                end
                            end
                            OP_DRAIN:
                            begin
                                if (fill_reg != '0)
                                begin
                                    mem_rd_en      = 1'b1;
                                    mem_rd_addr    = '0;
                                    drain_idx_next = '0;
                                    state_next     = ST_READ;
                                end
                            end
                            default:
                            begin
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                // first matching entry wins; no match maps to index 0
                if (entry_hit)
                begin
                    idx_next   = scan_idx_reg;
                    state_next = ST_STEP;
                end
                else if (scan_idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_STEP;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 2'd1;
                end
            end

            ST_STEP:
            begin
                pos_next   = pos_sat;
                state_next = ST_EMIT;
                if (op_reg == OP_SAMPLE && (pos_sat > POS_PUSH_HI || pos_sat < POS_PUSH_LO))
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = fill_reg[ADDR_W-1:0];
                    mem_wr_data  = (pos_sat > POS_PUSH_HI);
                    fill_next    = fill_reg + FILL_W'(1);
                    pos_next     = '0;
                    res_has_next = 1'b1;
                    res_dir_next = (pos_sat > POS_PUSH_HI);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_has_next   = res_has_reg;
                    out_dir_next   = res_dir_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_READ:
            begin
                state_next = ST_RD_EMIT;
            end

            ST_RD_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_has_next   = 1'b1;
                    out_dir_next   = rd_data_reg;
                    if (op_reg == OP_POP)
                    begin
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (drain_last)
                    begin
                        out_last_next = 1'b1;
                        fill_next     = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_last_next  = 1'b0;
                        drain_idx_next = drain_inc;
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = drain_inc[ADDR_W-1:0];
                        state_next     = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            code_table_reg <= CODE_TABLE_RESET;
            enable_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_CODE_TABLE:  code_table_reg <= cfg_data;
                    CFG_CONSUMER_EN: enable_reg     <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        code_reg      <= code_next;
        scan_idx_reg  <= scan_idx_next;
        idx_reg       <= idx_next;
        drain_idx_reg <= drain_idx_next;
        res_has_reg   <= res_has_next;
        res_dir_reg   <= res_dir_next;
        out_has_reg   <= out_has_next;
        out_dir_reg   <= out_dir_next;
        out_last_reg  <= out_last_next;
    end

    // bit stack: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_W'(STACK_DEPTH), "fill level above depth")
    `ASSERT_ALWAYS(a_pos_range, pos_reg != 4'sb1000, "count outside saturation range")
    `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "accepted while busy")
    `ASSERT_ALWAYS(a_dir_needs_bit, !out_valid_reg || out_has_reg || !out_dir_reg,
                   "direction set without a bit")

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadrature detent bit stack core. A shadow
// decoder tracks the step count and the bit stack for every accepted
// operation and queues the result transactions it predicts. A monitor
// compares each result transaction field by field against that queue, while
// both channels stall in random bursts and the code table and the consumer
// enable are moved through several settings between phases.
// ----------------------------------------------------------------------------
module testbench;
    import qdbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 2;        // 4 ns period
    localparam int RESET_CYC   = 11;
    localparam int SETTLE_CYC  = 8;        // settle time before a register write
    localparam int HOLD_CYC    = 300;      // long receiver hold-off
    localparam int CYCLE_LIMIT = 500_000;

    // config indexes that the core ignores
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = CFG_INDEX_W'(3);

    typedef struct packed {
        logic has_bit;
        logic direction;
        logic last;
    } result_t;

    // ------------------------------------------------------------------------
    // DUT signals, inputs driven known from time zero
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [1:0]             op        = OP_SAMPLE;
    logic                   clk_level = 1'b0;
    logic                   dt_level  = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   has_bit;
    logic                   direction;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // ------------------------------------------------------------------------
    // Shadow decoder state: mirrors the core's registers and stack
    // ------------------------------------------------------------------------
    logic [7:0] shadow_codes  = CODE_TABLE_RESET;
    logic       shadow_enable = 1'b0;
    int         det_count     = 0;              // signed step count
    logic       stack_bits [STACK_DEPTH];
    int         stack_fill    = 0;

    result_t    results_due [$];                // predicted, not yet seen

    // bookkeeping
    int ops_sent        = 0;
    int results_checked = 0;
    int detents_pushed  = 0;
    int full_drops      = 0;
    int reg_writes      = 0;
    int mismatches      = 0;
    int cycles          = 0;

    // stall control
    bit tx_idling   = 1'b1;     // sender gaps, read only by the sending process
    bit rx_idling   = 1'b1;     // receiver gaps, updated by NBA
    bit rx_hold     = 1'b0;     // long hold-off, updated by NBA
    int rx_gap_left = 0;

    quadrature_detent_bit_stack_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .clk_level (clk_level),
        .dt_level  (dt_level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .has_bit   (has_bit),
        .direction (direction),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: a correct run ends far below this.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, results_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shadow decoder
    // ------------------------------------------------------------------------
    function automatic void queue_result(logic h, logic d, logic l);
        result_t r;
        r.has_bit   = h;
        r.direction = d;
        r.last      = l;
        results_due.push_back(r);
    endfunction

    // Table index of a pin code; codes missing from the table land on entry 0,
    // and with a repeated code the lowest entry wins.
    function automatic int code_index(logic [1:0] code);
        for (int i = 0; i < 4; i++)
            if (shadow_codes[2*i +: 2] == code)
                return i;
        return 0;
    endfunction

    // Shortest step from the count's own phase to the sampled index.
    // A two-phase jump moves by the plain difference.
    function automatic void count_step(logic a, logic b);
        int idx;
        int phase;
        int diff;
        idx   = code_index({a, b});
        phase = ((det_count % 4) + 4) % 4;
        diff  = idx - phase;
        if (diff == 3)
            diff = -1;
        else if (diff == -3)
            diff = 1;
        det_count += diff;
        if (det_count > POS_SAT_HI)
            det_count = POS_SAT_HI;
        if (det_count < POS_SAT_LO)
            det_count = POS_SAT_LO;
    endfunction

    // Applies one accepted operation and queues its result transactions.
    function automatic void stack_op(op_t kind, logic a, logic b);
        logic dir_bit;
        if (!shadow_enable)
        begin
            queue_result(1'b0, 1'b0, 1'b1);
            return;
        end
        case (kind)
            OP_SAMPLE:
            begin
                if (stack_fill >= STACK_DEPTH)
                begin
                    // full stack: the sample is dropped, count untouched
                    full_drops++;
                    queue_result(1'b0, 1'b0, 1'b1);
                end
                else
                begin
                    count_step(a, b);
                    if (det_count > POS_PUSH_HI || det_count < POS_PUSH_LO)
                    begin
                        dir_bit = (det_count > POS_PUSH_HI);
                        stack_bits[stack_fill] = dir_bit;
                        stack_fill++;
                        det_count = 0;
                        detents_pushed++;
                        queue_result(1'b1, dir_bit, 1'b1);
                    end
                    else
                        queue_result(1'b0, 1'b0, 1'b1);
                end
            end
            OP_POP:
            begin
                if (stack_fill == 0)
                    queue_result(1'b0, 1'b0, 1'b1);
                else
                begin
                    stack_fill--;
                    queue_result(1'b1, stack_bits[stack_fill], 1'b1);
                end
            end
            OP_DRAIN:
            begin
                if (stack_fill == 0)
                    queue_result(1'b0, 1'b0, 1'b1);
                else
                begin
                    // oldest first, last flag on the newest
                    for (int i = 0; i < stack_fill; i++)
                        queue_result(1'b1, stack_bits[i], i == stack_fill - 1);
                    stack_fill = 0;
                end
            end
            OP_INIT:
            begin
                // moves the count with no push, even on a full stack
                count_step(a, b);
                queue_result(1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Pin code that sits `offset` phases away from the current count phase.
    function automatic logic [1:0] phase_code(int offset);
        int phase;
        phase = ((det_count % 4) + 8 + offset) % 4;
        return shadow_codes[2*phase +: 2];
    endfunction

    function automatic logic [7:0] shuffled_codes();
        logic [1:0] c [4];
        logic [1:0] t;
        int         j;
        for (int i = 0; i < 4; i++)
            c[i] = 2'(i);
        for (int i = 3; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            t    = c[i];
            c[i] = c[j];
            c[j] = t;
        end
        return {c[3], c[2], c[1], c[0]};
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor: every accepted result transaction is matched against
    // the oldest prediction.
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (results_due.size() == 0)
            begin
                $error("unexpected result transaction: has_bit %0b direction %0b last %0b",
                       has_bit, direction, last);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("has_bit", want.has_bit, has_bit);
                check_field("direction", want.direction, direction);
                check_field("last", want.last, last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure bursts, plus a long hold-off when a test
    // asks for one.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold)
            out_ready <= 1'b0;
        else if (rx_gap_left != 0)
        begin
            out_ready   <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end
        else if (rx_idling && $urandom_range(0, 5) == 0)
        begin
            out_ready   <= 1'b0;
            rx_gap_left <= $urandom_range(0, 8);
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One operation transaction; valid stays up across back-to-back calls.
    task automatic send_op(op_t kind, logic a, logic b);
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        clk_level <= a;
        dt_level  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        stack_op(kind, a, b);
        ops_sent++;
    endtask

    // Sample the code `offset` phases from the current one: +1 clockwise,
    // -1 counter-clockwise, 2 the opposite code, 0 no movement.
    task automatic turn(int offset, op_t kind);
        logic [1:0] code;
        code = phase_code(offset);
        send_op(kind, code[1], code[0]);
    endtask

    // Sender pause until every predicted result is in, then let the core
    // settle so a write cannot overlap an operation still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CODE_TABLE)
            shadow_codes = data;
        else if (idx == CFG_CONSUMER_EN)
            shadow_enable = data[0];
        reg_writes++;
    endtask

    // Mostly clean rotation runs with random direction and length, which is
    // what gets detents pushed; the rest is init runs, pops, drains, pauses
    // and raw noise. Pauses only happen while sender idling is on.
    task automatic random_traffic(int n);
        int stop;
        int pick;
        int dir;
        int run;
        stop = ops_sent + n;
        while (ops_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            dir  = $urandom_range(0, 1) ? 1 : -1;
            run  = $urandom_range(1, 10);
            if (pick < 55)
                repeat (run) turn(($urandom_range(0, 7) == 0) ? 2 : dir, OP_SAMPLE);
            else if (pick < 65)
                repeat (run) turn(dir, OP_INIT);
            else if (pick < 76)
                send_op(OP_POP, $urandom_range(0, 1), $urandom_range(0, 1));
            else if (pick < 82)
                send_op(OP_DRAIN, $urandom_range(0, 1), $urandom_range(0, 1));
            else if (pick < 85)
            begin
                if (tx_idling)
                    wait_idle();
            end
            else
                send_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                        $urandom_range(0, 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the consumer is off: every op answers one empty result.
    task automatic test_consumer_disabled();
        send_op(OP_SAMPLE, 1'b0, 1'b1);
        send_op(OP_POP, 1'b1, 1'b0);
        send_op(OP_DRAIN, 1'b1, 1'b1);
        send_op(OP_INIT, 1'b0, 1'b0);
    endtask

    // Detents both ways, opposite codes, drain order, empty stack, and the
    // count clamping at +7 through init samples.
    task automatic test_detent_basics();
        write_reg(CFG_CONSUMER_EN, 8'h01);
        send_op(OP_INIT, 1'b1, 1'b1);
        repeat (4) turn(1, OP_SAMPLE);      // clockwise detent
        repeat (4) turn(-1, OP_SAMPLE);     // counter-clockwise detent
        turn(2, OP_SAMPLE);                 // +2 jump
        turn(2, OP_SAMPLE);                 // and back by -2
        send_op(OP_DRAIN, 1'b0, 1'b0);      // 1 then 0
        send_op(OP_POP, 1'b1, 1'b0);        // empty
        send_op(OP_DRAIN, 1'b1, 1'b1);      // empty
        repeat (8) turn(1, OP_INIT);        // runs into the +7 clamp
        turn(0, OP_SAMPLE);                 // no movement, count still pushes
        send_op(OP_POP, 1'b0, 1'b1);
    endtask

    // Fill the stack, hit it with samples, then drain it while the receiver
    // holds off so the core backs up and stalls the operation channel.
    task automatic test_stack_full();
        int dir;
        write_reg(CFG_CODE_TABLE, CODE_TABLE_RESET);
        write_reg(CFG_CONSUMER_EN, 8'h01);
        send_op(OP_DRAIN, 1'b0, 1'b0);
        while (stack_fill < STACK_DEPTH)
        begin
            dir = $urandom_range(0, 1) ? 1 : -1;
            repeat (4) turn(dir, OP_SAMPLE);
        end
        repeat (3) send_op(OP_SAMPLE, $urandom_range(0, 1), $urandom_range(0, 1));
        turn(1, OP_INIT);                   // init still moves the count

        tx_idling = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYC) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        send_op(OP_DRAIN, 1'b1, 1'b0);
        repeat (6) send_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                           $urandom_range(0, 1));
        tx_idling = 1'b1;
    endtask

    // Table extremes, repeated codes, unknown codes, ignored indexes, and a
    // stretch with the consumer switched off mid-run.
    task automatic test_code_tables();
        write_reg(CFG_CODE_TABLE, 8'h00);
        random_traffic(12);
        write_reg(CFG_CODE_TABLE, 8'hFF);
        random_traffic(12);
        write_reg(CFG_CODE_TABLE, 8'b10_01_01_11);  // 00 missing, 01 twice
        random_traffic(15);
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'h00);
        write_reg(CFG_CONSUMER_EN, 8'h00);
        random_traffic(8);
        write_reg(CFG_CONSUMER_EN, 8'hFF);
        write_reg(CFG_CODE_TABLE, shuffled_codes());
        random_traffic(15);
    endtask

    // Several random settings, each with its own stall mix.
    task automatic test_random_settings();
        logic [7:0] codes;
        logic       en;
        for (int p = 0; p < 7; p++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: codes = shuffled_codes();
                5:             codes = CODE_TABLE_RESET;
                6:             codes = 8'h00;
                7:             codes = 8'hFF;
                default:       codes = 8'($urandom);
            endcase
            en = ($urandom_range(0, 6) != 0);
            write_reg(CFG_CODE_TABLE, codes);
            write_reg(CFG_CONSUMER_EN, {7'($urandom), en});
            tx_idling = ($urandom_range(0, 2) != 0);
            rx_idling <= ($urandom_range(0, 2) != 0);
            random_traffic(en ? 45 : 12);
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_no_idle_tail();
        write_reg(CFG_CODE_TABLE, CODE_TABLE_RESET);
        write_reg(CFG_CONSUMER_EN, 8'h01);
        tx_idling = 1'b0;
        rx_idling <= 1'b0;
        random_traffic(40);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        test_consumer_disabled();
        test_detent_basics();
        test_stack_full();
        test_code_tables();
        test_random_settings();
        test_no_idle_tail();

        wait_idle();
        $display("Covered %0d operation transactions, %0d result transactions, %0d register writes.",
                 ops_sent, results_checked, reg_writes);
        $display("Detent bits pushed: %0d; samples dropped on a full stack: %0d.",
                 detents_pushed, full_drops);
        if (mismatches == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/qdbs_pkg.sv
rtl/core/quadrature_detent_bit_stack_core.sv
sim/testbench.sv
